// ===== hdl/tlpt_pkg.sv =====
// Package for the two-level page table: widths, operation codes, request and result types, back states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tlpt_pkg;
	localparam int TABLE_SLOTS_DEF = 16;
	localparam int IDX_W = 10;
	localparam int OFF_W = 12;
	localparam int ADDR_W = 32;
	localparam int FLAG_W = 12;

	typedef enum logic [1:0] {
		OP_MAP = 2'd0,
		OP_UNMAP = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0] op;
		logic [ADDR_W-1:0] virt;
		logic [ADDR_W-1:0] phys;
		logic [FLAG_W-1:0] flags;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic user;
		logic nomap;
		logic full;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIR,
		ST_TBL,
		ST_OUT
	} bst_t;
endpackage
`default_nettype wire

// ===== hdl/tlpt_if.sv =====
// Valid/ready channel interface carrying one word of type T.
// Depends on tlpt_pkg for payload types.
`timescale 1ns / 1ps
`default_nettype none
interface tlpt_if #(parameter type T = tlpt_pkg::req_t) (input wire logic clk);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/tlpt_front.sv =====
// Front part: accepts request words into a two-entry queue.
// Depends on tlpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlpt_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire tlpt_pkg::req_t in_data,
	output logic q_valid,
	input wire logic q_ready,
	output tlpt_pkg::req_t q_data
);
	tlpt_pkg::req_t mem_q [2];
	logic rp_q, wp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_data = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= 1'b0;
			wp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== hdl/tlpt_back.sv =====
// Back part: directory and table memories, clear sweep, result register.
// Depends on tlpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlpt_back #(
	parameter int TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_ready,
	input wire tlpt_pkg::req_t q_data,
	output logic out_valid,
	input wire logic out_ready,
	output tlpt_pkg::res_t out_data
);
	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam int TA_W = SLOT_W + tlpt_pkg::IDX_W;
	localparam int DEPTH = TABLE_SLOTS * 1024;
	localparam int DIR_W = SLOT_W + 2;

	logic [DIR_W-1:0] dir_mem [1024];
	logic [31:0] tbl_mem [DEPTH];

	tlpt_pkg::bst_t st_q, st_d;
	tlpt_pkg::req_t req_q;
	logic [DIR_W-1:0] dir_rd_q;
	logic [31:0] tbl_rd_q;
	logic [CNT_W-1:0] used_q;
	logic clr_q;
	logic [TA_W:0] clr_cnt_q;
	logic full_q;
	tlpt_pkg::res_t res_q;
	tlpt_pkg::res_t res_d;
	logic oval_q;

	logic [9:0] di, ti;
	logic dpres, duser, need, full;
	logic [SLOT_W-1:0] slot;
	logic [DIR_W-1:0] dir_new;
	logic [TA_W-1:0] taddr;
	logic tbl_we;
	logic [31:0] tbl_wd;

	assign di = req_q.virt[31:22];
	assign ti = req_q.virt[21:12];
	assign dpres = dir_rd_q[0];
	assign need = !dpres;
	assign full = need && (used_q >= CNT_W'(TABLE_SLOTS));
	assign slot = need ? used_q[SLOT_W-1:0] : dir_rd_q[DIR_W-1:2];
	assign duser = need ? 1'b0 : dir_rd_q[1];
	assign dir_new = {slot, duser | req_q.flags[2], 1'b1};
	assign taddr = {slot, ti};
	assign q_ready = (st_q == tlpt_pkg::ST_IDLE) && !clr_q;
	assign out_valid = oval_q;
	assign out_data = res_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			tlpt_pkg::ST_IDLE: if (q_valid && !clr_q) st_d = tlpt_pkg::ST_DIR;
			tlpt_pkg::ST_DIR: st_d = tlpt_pkg::ST_TBL;
			tlpt_pkg::ST_TBL: st_d = tlpt_pkg::ST_OUT;
			tlpt_pkg::ST_OUT: if (!oval_q || out_ready) st_d = tlpt_pkg::ST_IDLE;
			default: st_d = tlpt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		tbl_we = 1'b0;
		tbl_wd = 32'd0;
		if (st_q == tlpt_pkg::ST_DIR) begin
			if (req_q.op == tlpt_pkg::OP_MAP && !full) begin
				tbl_we = 1'b1;
				tbl_wd = {req_q.phys[31:12], req_q.flags[11:1], 1'b1};
			end else if (req_q.op == tlpt_pkg::OP_UNMAP && dpres) begin
				tbl_we = 1'b1;
			end
		end
	end

	always_comb begin
		res_d = '0;
		case (req_q.op)
			tlpt_pkg::OP_MAP: res_d.full = full_q;
			tlpt_pkg::OP_LOOKUP: begin
				if (!dpres || !tbl_rd_q[0]) begin
					res_d.addr = '1;
					res_d.nomap = 1'b1;
				end else begin
					res_d.addr = {tbl_rd_q[31:12], req_q.virt[11:0]};
					res_d.user = dir_rd_q[1] && tbl_rd_q[2];
				end
			end
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == tlpt_pkg::ST_IDLE) begin
			req_q <= q_data;
			dir_rd_q <= dir_mem[q_data.virt[31:22]];
		end
		if (clr_q)
			dir_mem[clr_cnt_q[9:0]] <= '0;
		else if (st_q == tlpt_pkg::ST_DIR && req_q.op == tlpt_pkg::OP_MAP && !full)
			dir_mem[di] <= dir_new;
		if (clr_q)
			tbl_mem[clr_cnt_q[TA_W-1:0]] <= 32'd0;
		else if (tbl_we)
			tbl_mem[taddr] <= tbl_wd;
		if (st_q == tlpt_pkg::ST_DIR)
			tbl_rd_q <= tbl_mem[taddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tlpt_pkg::ST_IDLE;
			used_q <= '0;
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			full_q <= 1'b0;
			oval_q <= 1'b0;
			res_q <= '0;
		end else begin
			st_q <= st_d;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (TA_W+1)'(DEPTH - 1)) clr_q <= 1'b0;
			end
			if (st_q == tlpt_pkg::ST_DIR) begin
				full_q <= full;
				if (req_q.op == tlpt_pkg::OP_MAP && !full && need)
					used_q <= used_q + 1'b1;
			end
			if (st_q == tlpt_pkg::ST_OUT && (!oval_q || out_ready)) begin
				oval_q <= 1'b1;
				res_q <= res_d;
			end else if (oval_q && out_ready) begin
				oval_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/two_level_page_table_top.sv =====
// Top level of the two-level page table: front queue and back engine.
// Depends on tlpt_pkg, tlpt_if, tlpt_front, tlpt_back.
//
// channel  dir  payload
// req      in   operation, virt_address, phys_address, page_flags
// rsp      out  translated_address, user_accessible, not_mapped, table_full
//
// Each word passes the back-end steps of directory read, table access, a spare
// step and result register; rsp is valid once the result register is loaded.
// After reset the table and directory memories are swept to zero; during the
// sweep no word leaves the front queue.
// A stalled result holds the back.
`timescale 1ns / 1ps
`default_nettype none
module two_level_page_table_top #(
	parameter int TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	tlpt_if.sink req,
	tlpt_if.source rsp
);
	logic q_valid, q_ready;
	tlpt_pkg::req_t q_data;

	tlpt_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	tlpt_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
	);
endmodule
`default_nettype wire
